### hw/rtl/tun_pkg.sv
// shared constants for the triangle unit normal pipeline
package tun_pkg;

   // three vector components per item
   localparam int LANES = 3;
   // width of each unit normal component on the result bus
   localparam int OUT_BITS = 16;
   // vertices per triangle
   localparam int VERTS = 3;

endpackage

### hw/rtl/tun_cross.sv
// edge vectors, partial products and cross product magnitudes (three stages)
module tun_cross #(
   parameter int CB = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [9*CB-1:0]     vert,
   output logic [2*CB+1:0]     mag [3],
   output logic                neg [3]
);
   import tun_pkg::*;

   localparam int EB = CB + 1;
   localparam int PB = 2 * EB;
   localparam int NB = PB + 1;

   logic signed [CB-1:0] crd [VERTS*LANES];
   logic signed [EB-1:0] a_in [LANES];
   logic signed [EB-1:0] b_in [LANES];
   logic signed [EB-1:0] a_ff [LANES];
   logic signed [EB-1:0] b_ff [LANES];
   logic signed [PB-1:0] p_in [2*LANES];
   logic signed [PB-1:0] p_ff [2*LANES];
   logic signed [NB-1:0] n_in [LANES];
   logic [PB-1:0]        mag_in [LANES];
   logic                 neg_in [LANES];
   logic [PB-1:0]        mag_ff [LANES];
   logic                 neg_ff [LANES];

   // unpack coordinates and form edges from vertex 0
   always_comb begin
      for (int j = 0; j < VERTS*LANES; j++) begin
         crd[j] = vert[j*CB +: CB];
      end
      for (int i = 0; i < LANES; i++) begin
         a_in[i] = EB'(crd[LANES + i]) - EB'(crd[i]);
         b_in[i] = EB'(crd[2*LANES + i]) - EB'(crd[i]);
      end
   end

   // partial products of the cross product
   always_comb begin
      p_in[0] = PB'(a_ff[1]) * PB'(b_ff[2]);
      p_in[1] = PB'(a_ff[2]) * PB'(b_ff[1]);
      p_in[2] = PB'(a_ff[2]) * PB'(b_ff[0]);
      p_in[3] = PB'(a_ff[0]) * PB'(b_ff[2]);
      p_in[4] = PB'(a_ff[0]) * PB'(b_ff[1]);
      p_in[5] = PB'(a_ff[1]) * PB'(b_ff[0]);
   end

   // component difference split into sign and magnitude
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         n_in[i]   = NB'(p_ff[2*i]) - NB'(p_ff[2*i+1]);
         neg_in[i] = n_in[i][NB-1];
         mag_in[i] = neg_in[i] ? PB'(-n_in[i]) : PB'(n_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         p_ff   <= p_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

### hw/rtl/tun_sumsq.sv
// squares, squared length and starting remainder of the rounding search (two stages)
module tun_sumsq #(
   parameter int MB = 34,
   parameter int F  = 14,
   parameter int SB = 2*MB + 2,
   parameter int WB = SB + 2*F + 4
) (
   input  logic           clock,
   input  logic           en,
   input  logic [MB-1:0]  mag [3],
   input  logic           neg [3],
   output logic [SB-1:0]  s,
   output logic [WB-1:0]  rem [3],
   output logic           neg_o [3],
   output logic           deg
);
   import tun_pkg::*;

   localparam int SQ = 2 * MB;

   logic [SQ-1:0] sq_in [LANES];
   logic [SQ-1:0] sq_ff [LANES];
   logic          n1_ff [LANES];
   logic [SB-1:0] s_in;
   logic [WB-1:0] rem_in [LANES];
   logic          deg_in;
   logic [SB-1:0] s_ff;
   logic [WB-1:0] rem_ff [LANES];
   logic          n2_ff [LANES];
   logic          deg_ff;

   // squares of the component magnitudes
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sq_in[i] = SQ'(mag[i]) * SQ'(mag[i]);
      end
   end

   // squared length; remainder starts at c^2 * 4^(F+1) - S
   always_comb begin
      s_in   = SB'(sq_ff[0]) + SB'(sq_ff[1]) + SB'(sq_ff[2]);
      deg_in = (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
      for (int i = 0; i < LANES; i++) begin
         rem_in[i] = (WB'(sq_ff[i]) << (2*F + 2)) - WB'(sq_ff[0]) - WB'(sq_ff[1])
                     - WB'(sq_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= sq_in;
         n1_ff  <= neg;
         s_ff   <= s_in;
         rem_ff <= rem_in;
         n2_ff  <= n1_ff;
         deg_ff <= deg_in;
      end
   end

   assign s     = s_ff;
   assign rem   = rem_ff;
   assign neg_o = n2_ff;
   assign deg   = deg_ff;

endmodule

### hw/rtl/tun_step.sv
// one bit of the rounded quotient for all three components (one stage)
module tun_step #(
   parameter int F  = 14,
   parameter int K  = 14,
   parameter int SB = 70,
   parameter int WB = SB + 2*F + 4
) (
   input  logic           clock,
   input  logic           en,
   input  logic [SB-1:0]  s_i,
   input  logic [WB-1:0]  rem_i [3],
   input  logic [WB-1:0]  qs_i [3],
   input  logic [F:0]     q_i [3],
   input  logic           neg_i [3],
   input  logic           deg_i,
   output logic [SB-1:0]  s_o,
   output logic [WB-1:0]  rem_o [3],
   output logic [WB-1:0]  qs_o [3],
   output logic [F:0]     q_o [3],
   output logic           neg_o [3],
   output logic           deg_o
);
   import tun_pkg::*;

   // with e = 2q, rem = c^2*4^(F+1) - (e-1)^2*S and qs = e*S
   logic [WB-1:0] s_w;
   logic [WB-1:0] trial [LANES];
   logic [WB-1:0] rem_in [LANES];
   logic [WB-1:0] qs_in [LANES];
   logic [F:0]    q_in [LANES];
   logic [SB-1:0] s_ff;
   logic [WB-1:0] rem_ff [LANES];
   logic [WB-1:0] qs_ff [LANES];
   logic [F:0]    q_ff [LANES];
   logic          neg_ff [LANES];
   logic          deg_ff;

   // try setting bit K of q; keep it when the remainder stays non-negative
   always_comb begin
      s_w = WB'(s_i);
      for (int i = 0; i < LANES; i++) begin
         trial[i] = rem_i[i] - (qs_i[i] << (K + 2)) + (s_w << (K + 2))
                    - (s_w << (2*K + 2));
         if (!trial[i][WB-1]) begin
            rem_in[i] = trial[i];
            qs_in[i]  = qs_i[i] + (s_w << (K + 1));
            q_in[i]   = q_i[i] | ((F+1)'(1) << K);
         end else begin
            rem_in[i] = rem_i[i];
            qs_in[i]  = qs_i[i];
            q_in[i]   = q_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_i;
         rem_ff <= rem_in;
         qs_ff  <= qs_in;
         q_ff   <= q_in;
         neg_ff <= neg_i;
         deg_ff <= deg_i;
      end
   end

   assign s_o   = s_ff;
   assign rem_o = rem_ff;
   assign qs_o  = qs_ff;
   assign q_o   = q_ff;
   assign neg_o = neg_ff;
   assign deg_o = deg_ff;

endmodule

### hw/rtl/triangle_unit_normal.sv
// Unit surface normal of a triangle: edges from vertex 0, exact integer cross
// product, then each component divided by the vector length and rounded to
// nearest (ties away from zero) in signed fixed point with 1.0 = 2^FRAC_BITS.
// A zero-length normal gives a zero vector with the degenerate flag set. The
// pipeline takes one triangle every cycle unless the result side stalls; it has
// three cross product stages, two squared length stages, one stage per
// quotient bit of the rounding search and one output stage. A stall on the
// result side holds the whole pipeline.
module triangle_unit_normal #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // unit_x, unit_y, unit_z
   output logic [3*tun_pkg::OUT_BITS-1:0]           rsp_tdata,
   // degenerate
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready
);
   import tun_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int MB  = 2*CB + 2;
   localparam int SB  = 2*MB + 2;
   localparam int WB  = SB + 2*F + 4;
   localparam int LAT = F + 7;

   logic               en;
   logic [LAT-1:0]     valid_ff;
   logic [MB-1:0]      mag [LANES];
   logic               neg_c [LANES];

   logic [SB-1:0]      s_c   [F+2];
   logic [WB-1:0]      rem_c [F+2][LANES];
   logic [WB-1:0]      qs_c  [F+2][LANES];
   logic [F:0]         q_c   [F+2][LANES];
   logic               neg_s [F+2][LANES];
   logic               deg_c [F+2];

   logic [31:0]        qx [LANES];
   logic [OUT_BITS-1:0] unit_in [LANES];
   logic [OUT_BITS-1:0] unit_ff [LANES];
   logic               deg_ff;

   // whole pipeline advances unless a finished result is stalled
   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   // valid bits move with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   tun_cross #(.CB(CB)) u_cross (
      .clock (clock),
      .en    (en),
      .vert  (req_tdata[9*CB-1:0]),
      .mag   (mag),
      .neg   (neg_c)
   );

   tun_sumsq #(.MB(MB), .F(F), .SB(SB), .WB(WB)) u_sumsq (
      .clock (clock),
      .en    (en),
      .mag   (mag),
      .neg   (neg_c),
      .s     (s_c[0]),
      .rem   (rem_c[0]),
      .neg_o (neg_s[0]),
      .deg   (deg_c[0])
   );

   // search starts from q = 0
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         qs_c[0][i] = '0;
         q_c[0][i]  = '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar g = 0; g <= F; g++) begin : g_step
      tun_step #(.F(F), .K(F - g), .SB(SB), .WB(WB)) u_step (
         .clock (clock),
         .en    (en),
         .s_i   (s_c[g]),
         .rem_i (rem_c[g]),
         .qs_i  (qs_c[g]),
         .q_i   (q_c[g]),
         .neg_i (neg_s[g]),
         .deg_i (deg_c[g]),
         .s_o   (s_c[g+1]),
         .rem_o (rem_c[g+1]),
         .qs_o  (qs_c[g+1]),
         .q_o   (q_c[g+1]),
         .neg_o (neg_s[g+1]),
         .deg_o (deg_c[g+1])
      );
   end

   // apply the sign, zero out degenerate triangles
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         qx[i] = 32'(q_c[F+1][i]);
         if (deg_c[F+1]) begin
            unit_in[i] = '0;
         end else if (neg_s[F+1][i]) begin
            unit_in[i] = OUT_BITS'(-qx[i]);
         end else begin
            unit_in[i] = OUT_BITS'(qx[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
         deg_ff  <= deg_c[F+1];
      end
   end

   assign rsp_tdata  = {unit_ff[2], unit_ff[1], unit_ff[0]};
   assign rsp_tuser  = deg_ff;
   assign rsp_tvalid = valid_ff[LAT-1];

   // a degenerate result carries a zero vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero components");

   // a stalled pipeline keeps its occupancy
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(valid_ff))
      else $error("pipeline occupancy changed during stall");

   // nothing leaves the pipeline right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

### bench/triangle_unit_normal_tb.sv
// testbench for the triangle unit normal pipeline with its own scoreboard
module triangle_unit_normal_tb;
   import tun_pkg::*;

   localparam int CB = 16;
   localparam int FB = 14;
   localparam int IN_W = ((9*CB+7)/8)*8;

   typedef logic signed [CB-1:0] coord_type;
   typedef coord_type tri_type [9];

   typedef struct {
      logic [OUT_BITS-1:0] comp [LANES];
      logic                degen;
   } normal_type;

   // expected normals in arrival order, checked against the result transfers
   class normal_scoreboard;
      normal_type pending [$];
      int      mismatches;
      int      degen_seen;
      int      checked;

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // largest q in [0, 2^FB] with (2q-1)^2 * total <= part * 2^(2FB+2)
      function logic [OUT_BITS-1:0] round_unit(logic [127:0] part, logic [127:0] total);
         logic [127:0] lim, d, lhs;
         int unsigned lo, hi, mid;
         lim = part << (2*FB+2);
         lo = 0;
         hi = 1 << FB;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            d = 2*mid - 1;
            lhs = d * d * total;
            if (lhs <= lim) lo = mid;
            else hi = mid - 1;
         end
         return lo[OUT_BITS-1:0];
      endfunction

      function void note_triangle(tri_type v);
         longint a [3], b [3], n [3];
         logic [127:0] sq [3], total, mag;
         normal_type e;
         for (int k = 0; k < 3; k++) begin
            a[k] = longint'(v[3+k]) - longint'(v[k]);
            b[k] = longint'(v[6+k]) - longint'(v[k]);
         end
         n[0] = a[1]*b[2] - a[2]*b[1];
         n[1] = a[2]*b[0] - a[0]*b[2];
         n[2] = a[0]*b[1] - a[1]*b[0];
         total = 0;
         for (int k = 0; k < 3; k++) begin
            mag = (n[k] < 0) ? -n[k] : n[k];
            sq[k] = mag * mag;
            total += sq[k];
         end
         e.degen = (total == 0);
         for (int k = 0; k < 3; k++) begin
            if (e.degen) e.comp[k] = '0;
            else begin
               e.comp[k] = round_unit(sq[k], total);
               if (n[k] < 0) e.comp[k] = -e.comp[k];
            end
         end
         pending.push_back(e);
      endfunction

      task check_normal(logic [3*OUT_BITS-1:0] data, logic degen);
         normal_type e;
         if (pending.size() == 0) begin
            report("result transfer with nothing expected");
            return;
         end
         e = pending.pop_front();
         checked++;
         if (degen) degen_seen++;
         if (degen !== e.degen)
            report($sformatf("degenerate got %b want %b", degen, e.degen));
         for (int k = 0; k < LANES; k++)
            if (data[k*OUT_BITS +: OUT_BITS] !== e.comp[k])
               report($sformatf("component %0d got %h want %h",
                                k, data[k*OUT_BITS +: OUT_BITS], e.comp[k]));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic [IN_W-1:0]            req_tdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [3*OUT_BITS-1:0]      rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;

   normal_scoreboard sb;
   bit quiet;

   triangle_unit_normal dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3000000;
      $display("triangle_unit_normal_tb NOT OK");
      $finish;
   end

   // one triangle transfer, with an optional idle burst ahead of it
   task send_triangle(tri_type v);
      logic [IN_W-1:0] d;
      d = '0;
      for (int i = 0; i < 9; i++) d[i*CB +: CB] = v[i];
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_triangle(v);
   endtask

   function automatic coord_type rnd_coord(int span);
      if (span == 0) return coord_type'($urandom());
      return coord_type'($urandom_range(0, 2*span) - span);
   endfunction

   // result side: check transfers and stall in bursts
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_normal(rsp_tdata, rsp_tuser);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      tri_type v;
      coord_type mx, mn;
      int span;
      sb = new();
      mx = 16'sh7fff;
      mn = 16'sh8000;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all vertices coincide
      v = '{default: 0};
      send_triangle(v);
      // collinear points: both corners of the range and the origin
      v = '{mn, mn, mn, 0, 0, 0, mx, mx, mx};
      send_triangle(v);
      // unit axis normals, both signs, exact one
      v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_triangle(v);
      v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
      send_triangle(v);
      v = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
      send_triangle(v);
      v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
      send_triangle(v);
      // largest edges across the full range
      v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
      send_triangle(v);
      v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
      send_triangle(v);
      v = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
      send_triangle(v);
      v = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};
      send_triangle(v);
      // a diagonal normal, an axis normal, and two coincident vertices
      v = '{0, 0, 0, 1, -1, 0, 1, 0, -1};
      send_triangle(v);
      v = '{0, 0, 0, 3, 0, 0, 0, 4, 0};
      send_triangle(v);
      v = '{5, -7, 2, 5, -7, 2, 1, 1, 1};
      send_triangle(v);

      // random triangles: full range, small, and collinear
      for (int n = 0; n < 1000; n++) begin
         if (n >= 900) quiet = 1;
         case ($urandom_range(0, 5))
            0, 1: span = 0;
            2:    span = 3;
            3:    span = 200;
            default: span = 1 << $urandom_range(1, 14);
         endcase
         for (int i = 0; i < 9; i++) v[i] = rnd_coord(span);
         if ($urandom_range(0, 9) == 0) begin
            // third vertex on the line through the first two, unless the coordinates wrap
            for (int k = 0; k < 3; k++)
               v[6+k] = coord_type'(2*longint'(v[3+k]) - longint'(v[k]));
         end
         send_triangle(v);
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (FB + 20) @(posedge clock);

      $display("checked %0d normals, %0d of them degenerate, with random stalls",
               sb.checked, sb.degen_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("triangle_unit_normal_tb OK");
      end else begin
         $display("triangle_unit_normal_tb NOT OK");
      end
      $finish;
   end

endmodule
